@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/aesc_pkg.sv @@
// types, constants, s-box tables and round functions for the aes-128 cipher
// no dependencies
package aesc_pkg;

    localparam int BLK_W      = 128;
    localparam int HALF_W     = 64;
    localparam int LAST_ROUND = 10;
    localparam int KEY_ROWS   = 20;
    localparam int ROW_W      = $clog2(KEY_ROWS);
    localparam int RND_W      = $clog2(LAST_ROUND + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } aesc_state_t;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_FWD,
        KS_INV
    } ks_state_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } rk_rd_req_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic logic [7:0] rcon(input logic [RND_W-1:0] i);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    endfunction

    // coefficient index k-r within a column, forward {2,3,1,1}, inverse {14,11,13,9}
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [1:0] idx,
                                        input logic inv);
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        logic [7:0] p;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        if (!inv)
        begin
            case (idx)
                2'd0:    p = x2;
                2'd1:    p = x2 ^ a;
                default: p = a;
            endcase
        end
        else
        begin
            case (idx)
                2'd0:    p = x8 ^ x4 ^ x2;
                2'd1:    p = x8 ^ x2 ^ a;
                2'd2:    p = x8 ^ x4 ^ a;
                default: p = x8 ^ a;
            endcase
        end
        return p;
    endfunction

    function automatic logic [BLK_W-1:0] mix_columns(input logic [BLK_W-1:0] s,
                                                     input logic inv);
        logic [BLK_W-1:0] t;
        logic [7:0]       v;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                v = '0;
                for (int k = 0; k < 4; k++)
                begin
                    v = v ^ gmul(s[8*(4*c+k) +: 8], 2'(k - r), inv);
                end
                t[8*(4*c+r) +: 8] = v;
            end
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] sub_shift(input logic [BLK_W-1:0] s,
                                                   input logic inv);
        logic [BLK_W-1:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (!inv)
                    t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
                else
                    t[8*(r+4*c) +: 8] = INV_SBOX[s[8*(r+4*((c+4-r)%4)) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] next_key(input logic [BLK_W-1:0] k,
                                                  input logic [7:0] rc);
        logic [31:0]      w3;
        logic [31:0]      t;
        logic [BLK_W-1:0] n;
        w3 = k[127:96];
        t  = {SBOX[w3[7:0]], SBOX[w3[31:24]], SBOX[w3[23:16]], SBOX[w3[15:8]] ^ rc};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    // key row used by a round, inverse keys sit in rows 11 to 19
    function automatic logic [ROW_W-1:0] key_row(input logic [RND_W-1:0] rnd,
                                                 input logic op);
        logic [ROW_W-1:0] row;
        if (op == OP_ENC)
            row = ROW_W'(rnd);
        else if (rnd == RND_W'(0))
            row = ROW_W'(LAST_ROUND);
        else if (rnd == RND_W'(LAST_ROUND))
            row = '0;
        else
            row = ROW_W'(LAST_ROUND) + ROW_W'(rnd);
        return row;
    endfunction

endpackage

@@ rtl/aesc_in_if.sv @@
// input channel: op and block halves with valid/ready
// no dependencies
interface aesc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] block_low;
    logic [63:0] block_high;

    modport source (output valid, output op, output block_low, output block_high,
                    input ready);
    modport sink (input valid, input op, input block_low, input block_high,
                  output ready);
endinterface

@@ rtl/aesc_out_if.sv @@
// output channel: result halves with valid/ready
// no dependencies
interface aesc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;

    modport source (output valid, output result_low, output result_high, input ready);
    modport sink (input valid, input result_low, input result_high, output ready);
endinterface

@@ rtl/aesc_cfg_if.sv @@
// configuration write channel: register index and data with valid/ready
// no dependencies
interface aesc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/aesc_key_store.sv @@
// key expansion sequencer and round key memory (20 rows of 128 bits)
// depends on aesc_pkg and assert_macros.svh
`include "assert_macros.svh"

module aesc_key_store
    import aesc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [BLK_W-1:0] key,
    input  rk_rd_req_t       rd_req,
    output logic [BLK_W-1:0] rd_data,
    output logic             busy
);

    logic [BLK_W-1:0] mem [KEY_ROWS];
    logic [BLK_W-1:0] rd_data_reg;

    ks_state_t        state_reg, state_next;
    logic [RND_W-1:0] kcnt_reg, kcnt_next;
    logic [BLK_W-1:0] cur_reg, cur_next;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic [BLK_W-1:0] wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KS_IDLE;
            kcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kcnt_reg  <= kcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kcnt_next  = kcnt_reg;
        cur_next   = cur_reg;
        wr_en      = 1'b0;
        wr_addr    = ROW_W'(kcnt_reg);
        wr_data    = cur_reg;
        unique case (state_reg)
            KS_IDLE:
            begin
                if (start)
                begin
                    cur_next   = key;
                    kcnt_next  = '0;
                    state_next = KS_FWD;
                end
            end
            KS_FWD:
            begin
                wr_en = 1'b1;
                if (kcnt_reg == RND_W'(LAST_ROUND))
                    state_next = KS_IDLE;
                else if (kcnt_reg == RND_W'(0))
                begin
                    cur_next  = next_key(cur_reg, rcon(kcnt_reg));
                    kcnt_next = kcnt_reg + RND_W'(1);
                end
                else
                    state_next = KS_INV;
            end
            KS_INV:
            begin
                wr_en      = 1'b1;
                wr_addr    = ROW_W'(KEY_ROWS) - ROW_W'(kcnt_reg);
                wr_data    = mix_columns(cur_reg, 1'b1);
                cur_next   = next_key(cur_reg, rcon(kcnt_reg));
                kcnt_next  = kcnt_reg + RND_W'(1);
                state_next = KS_FWD;
            end
            default:
            begin
                state_next = KS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.en)
            rd_data_reg <= mem[rd_req.addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = (state_reg != KS_IDLE);

    `ASSERT_SAME(a_kcnt_range, clk, rst_n, 1'b1, kcnt_reg <= RND_W'(LAST_ROUND))
    `ASSERT_SAME(a_inv_mid, clk, rst_n, state_reg == KS_INV, kcnt_reg != RND_W'(0) && kcnt_reg != RND_W'(LAST_ROUND))
    `ASSERT_NEXT(a_start_runs, clk, rst_n, state_reg == KS_IDLE && start, state_reg == KS_FWD && kcnt_reg == RND_W'(0))

endmodule

@@ rtl/aes128_block_cipher.sv @@
// aes-128 ecb encrypt/decrypt top level with one shared round unit
// depends on aesc_pkg, aesc_in_if, aesc_out_if, aesc_cfg_if, aesc_key_store
//
// channel   dir  payload                          transaction
// in_ch     in   op, block_low, block_high        valid && ready
// out_ch    out  result_low, result_high          valid && ready
// cfg       in   index (0 key_low, 1 key_high)    valid && ready
//
// a block passes through the round unit as key add, nine full rounds, final round
// a key write starts the key expansion; in_ch and cfg are not ready meanwhile
// the round key memory holds no defined value until the first key write
// the result register frees the round unit; a full output stalls only the final round
`include "assert_macros.svh"

module aes128_block_cipher
    import aesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    aesc_in_if.sink    in_ch,
    aesc_out_if.source out_ch,
    aesc_cfg_if.sink   cfg
);

    aesc_state_t       state_reg, state_next;
    logic [RND_W-1:0]  round_reg, round_next;
    logic              op_reg, op_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [BLK_W-1:0]  res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [HALF_W-1:0] key_low_reg, key_low_next;
    logic [HALF_W-1:0] key_high_reg, key_high_next;

    logic              ks_start;
    logic              ks_busy;
    rk_rd_req_t        rd_req;
    logic [BLK_W-1:0]  rk;
    logic [BLK_W-1:0]  round_out;
    logic [BLK_W-1:0]  ss;
    logic              in_fire;
    logic              cfg_fire;
    logic              finish;

    aesc_key_store u_key_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ks_start),
        .key     ({key_high_next, key_low_next}),
        .rd_req  (rd_req),
        .rd_data (rk),
        .busy    (ks_busy)
    );

    assign in_ch.ready = (state_reg == ST_IDLE) && !ks_busy;
    assign cfg.ready   = (state_reg == ST_IDLE) && !ks_busy;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cfg_fire    = cfg.valid && cfg.ready;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        ks_start      = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_KEY_LOW:
                begin
                    key_low_next = cfg.data;
                    ks_start     = 1'b1;
                end
                CFG_KEY_HIGH:
                begin
                    key_high_next = cfg.data;
                    ks_start      = 1'b1;
                end
                default:
                begin
                    ks_start = 1'b0;
                end
            endcase
        end
    end

    // shared round unit
    always_comb
    begin
        ss = sub_shift(blk_reg, op_reg);
        if (round_reg == RND_W'(0))
            round_out = blk_reg ^ rk;
        else if (round_reg == RND_W'(LAST_ROUND))
            round_out = ss ^ rk;
        else
            round_out = mix_columns(ss, op_reg) ^ rk;
    end

    assign finish = (state_reg == ST_RUN) && (round_reg == RND_W'(LAST_ROUND))
                    && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        rd_req.en      = 1'b0;
        rd_req.addr    = key_row(RND_W'(0), in_ch.op);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = in_ch.op;
                    blk_next   = {in_ch.block_high, in_ch.block_low};
                    round_next = '0;
                    rd_req.en  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (round_reg != RND_W'(LAST_ROUND))
                begin
                    blk_next    = round_out;
                    round_next  = round_reg + RND_W'(1);
                    rd_req.en   = 1'b1;
                    rd_req.addr = key_row(round_reg + RND_W'(1), op_reg);
                end
                else if (finish)
                begin
                    res_next       = round_out;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        blk_reg <= blk_next;
        res_reg <= res_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_low  = res_reg[HALF_W-1:0];
    assign out_ch.result_high = res_reg[BLK_W-1:HALF_W];

    `ASSERT_SAME(a_round_range, clk, rst_n, 1'b1, round_reg <= RND_W'(LAST_ROUND))
    `ASSERT_SAME(a_busy_blocks, clk, rst_n, ks_busy || state_reg == ST_RUN, !in_ch.ready && !cfg.ready)
    `ASSERT_NEXT(a_finish_out, clk, rst_n, finish, out_valid_reg && state_reg == ST_IDLE)
    `ASSERT_NEXT(a_round_step, clk, rst_n, state_reg == ST_RUN && round_reg != RND_W'(LAST_ROUND), state_reg == ST_RUN && round_reg == $past(round_reg) + RND_W'(1))

endmodule
